/* design/sm64_pkg.sv */
package sm64_pkg;

   localparam int DATA_W        = 64;
   localparam int HALF_W        = 32;
   localparam int CMD_W         = 2;
   localparam int BYTE_COUNT_W  = 10;
   localparam int VALID_BYTES_W = 4;
   localparam int WORD_BYTES    = 8;

   localparam int DEFAULT_MAX_REQUEST_BYTES = 512;

   localparam logic [DATA_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [DATA_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [DATA_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
   localparam int                SHIFT_FIRST  = 30;
   localparam int                SHIFT_SECOND = 27;
   localparam int                SHIFT_THIRD  = 31;

   // The remainder unit retires one dividend bit per step.
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [CMD_W-1:0] {
      CMD_SEED     = 2'd0,
      CMD_GENERATE = 2'd1,
      CMD_UNIFORM  = 2'd2,
      CMD_UNUSED   = 2'd3
   } sm64_cmd_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SEED,
      OP_CAPTURE,
      OP_LOAD,
      OP_MUL_LL,
      OP_MUL_HL,
      OP_MUL_LH,
      OP_FOLD27,
      OP_FOLD31,
      OP_DIV_STEP,
      OP_PUT_GEN,
      OP_PUT_UNI,
      OP_PUT_ZERO
   } sm64_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_LL,
      ST_MUL_HL,
      ST_MUL_LH,
      ST_FOLD,
      ST_DIV,
      ST_PUT_GEN,
      ST_PUT_UNI,
      ST_PUT_ZERO
   } sm64_state_type;

   typedef struct packed {
      sm64_op_type op;
      logic        mul_b;
   } sm64_dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic count_zero;
      logic bound_zero;
      logic last_chunk;
   } sm64_dp_status_type;

endpackage

/* design/sm64_if.sv */
interface sm64_req_if import sm64_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [BYTE_COUNT_W-1:0]   byte_count;
   logic [DATA_W-1:0]         bound;
   logic [DATA_W-1:0]         entropy;

   modport source (output valid, output cmd, output byte_count, output bound,
                   output entropy, input ready);
   modport sink   (input valid, input cmd, input byte_count, input bound,
                   input entropy, output ready);
endinterface

interface sm64_rsp_if import sm64_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [DATA_W-1:0]         value;
   logic [VALID_BYTES_W-1:0]  valid_bytes;
   logic                      last;

   modport source (output valid, output value, output valid_bytes, output last,
                   input ready);
   modport sink   (input valid, input value, input valid_bytes, input last,
                   output ready);
endinterface

/* design/sm64_ctrl.sv */
module sm64_ctrl import sm64_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [CMD_W-1:0]   req_cmd,
   output logic               req_ready,
   input  sm64_dp_status_type status,
   output sm64_dp_cmd_type    dp_cmd
);

   sm64_state_type        state_ff, state_in;
   logic                  mul_b_ff, mul_b_in;
   logic                  uni_ff, uni_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   sm64_cmd_type          cmd_code;

   assign cmd_code = sm64_cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_b_ff   <= 1'b0;
         uni_ff     <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mul_b_ff   <= mul_b_in;
         uni_ff     <= uni_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mul_b_in     = mul_b_ff;
      uni_in       = uni_ff;
      div_cnt_in   = div_cnt_ff;
      req_ready    = 1'b0;
      dp_cmd.op    = OP_NONE;
      dp_cmd.mul_b = mul_b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (cmd_code)
                  CMD_SEED: begin
                     dp_cmd.op = OP_SEED;
                  end
                  CMD_GENERATE: begin
                     dp_cmd.op = OP_CAPTURE;
                     uni_in    = 1'b0;
                     if (!status.count_zero) begin
                        state_in = ST_LOAD;
                     end
                  end
                  CMD_UNIFORM: begin
                     dp_cmd.op = OP_CAPTURE;
                     uni_in    = 1'b1;
                     state_in  = status.bound_zero ? ST_PUT_ZERO : ST_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            dp_cmd.op = OP_LOAD;
            mul_b_in  = 1'b0;
            state_in  = ST_MUL_LL;
         end
         ST_MUL_LL: begin
            dp_cmd.op = OP_MUL_LL;
            state_in  = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            dp_cmd.op = OP_MUL_HL;
            state_in  = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            dp_cmd.op = OP_MUL_LH;
            state_in  = ST_FOLD;
         end
         ST_FOLD: begin
            if (!mul_b_ff) begin
               dp_cmd.op = OP_FOLD27;
               mul_b_in  = 1'b1;
               state_in  = ST_MUL_LL;
            end else begin
               dp_cmd.op  = OP_FOLD31;
               mul_b_in   = 1'b0;
               div_cnt_in = '0;
               state_in   = uni_ff ? ST_DIV : ST_PUT_GEN;
            end
         end
         ST_DIV: begin
            dp_cmd.op  = OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_PUT_UNI;
            end
         end
         ST_PUT_GEN: begin
            if (status.out_free) begin
               dp_cmd.op = OP_PUT_GEN;
               state_in  = status.last_chunk ? ST_IDLE : ST_LOAD;
            end
         end
         ST_PUT_UNI: begin
            if (status.out_free) begin
               dp_cmd.op = OP_PUT_UNI;
               state_in  = ST_IDLE;
            end
         end
         ST_PUT_ZERO: begin
            if (status.out_free) begin
               dp_cmd.op = OP_PUT_ZERO;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/sm64_datapath.sv */
module sm64_datapath import sm64_pkg::*; #(
   parameter int MAX_REQUEST_BYTES = DEFAULT_MAX_REQUEST_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sm64_dp_cmd_type           dp_cmd,
   output sm64_dp_status_type        status,
   input  logic [BYTE_COUNT_W-1:0]   req_byte_count,
   input  logic [DATA_W-1:0]         req_bound,
   input  logic [DATA_W-1:0]         req_entropy,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [DATA_W-1:0]         rsp_value,
   output logic [VALID_BYTES_W-1:0]  rsp_valid_bytes,
   output logic                      rsp_last
);

   localparam int CNT_W = $clog2(MAX_REQUEST_BYTES + 1);

   logic [DATA_W-1:0]         gen_state_ff, gen_state_in;
   logic [DATA_W-1:0]         entropy_ff, entropy_in;
   logic [DATA_W-1:0]         bound_ff, bound_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic [DATA_W-1:0]         acc_ff, acc_in;
   logic [DATA_W-1:0]         prod_ff, prod_in;
   logic [DATA_W-1:0]         z_ff, z_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         rsp_value_ff, rsp_value_in;
   logic [VALID_BYTES_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0]         mul_const;
   logic [HALF_W-1:0]         mul_opa, mul_opb;
   logic [DATA_W-1:0]         mul_out;
   logic [DATA_W-1:0]         fold_sum;
   logic [DATA_W-1:0]         draw_x;
   logic [DATA_W:0]           div_shift;
   logic [DATA_W:0]           div_diff;
   logic [VALID_BYTES_W-1:0]  chunk;
   logic [DATA_W-1:0]         masked_word;
   logic                      out_free;

   assign mul_const = dp_cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
   assign mul_out   = {{HALF_W{1'b0}}, mul_opa} * {{HALF_W{1'b0}}, mul_opb};
   assign fold_sum  = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign draw_x    = ((gen_state_ff != '0) ? gen_state_ff : entropy_ff) + GOLDEN_STEP;
   assign div_shift = {rem_ff, z_ff[DATA_W-1]};
   assign div_diff  = div_shift - {1'b0, bound_ff};

   assign chunk = (remain_ff >= CNT_W'(WORD_BYTES)) ? VALID_BYTES_W'(WORD_BYTES)
                                                    : VALID_BYTES_W'(remain_ff);

   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         masked_word[i*8 +: 8] = (VALID_BYTES_W'(i) < chunk) ? z_ff[i*8 +: 8] : 8'd0;
      end
   end

   assign out_free          = !rsp_valid_ff || rsp_ready;
   assign status.out_free   = out_free;
   assign status.count_zero = (req_byte_count == '0);
   assign status.bound_zero = (req_bound == '0);
   assign status.last_chunk = (remain_ff <= CNT_W'(WORD_BYTES));

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_state_ff <= gen_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entropy_ff   <= entropy_in;
      bound_ff     <= bound_in;
      remain_ff    <= remain_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      z_ff         <= z_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      gen_state_in = gen_state_ff;
      entropy_in   = entropy_ff;
      bound_in     = bound_ff;
      remain_in    = remain_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      z_in         = z_ff;
      rem_in       = rem_ff;
      mul_opa      = z_ff[HALF_W-1:0];
      mul_opb      = mul_const[HALF_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (dp_cmd.op)
         OP_SEED: begin
            gen_state_in = req_entropy;
         end
         OP_CAPTURE: begin
            entropy_in = req_entropy;
            bound_in   = req_bound;
            if (req_byte_count > BYTE_COUNT_W'(MAX_REQUEST_BYTES)) begin
               remain_in = CNT_W'(MAX_REQUEST_BYTES);
            end else begin
               remain_in = CNT_W'(req_byte_count);
            end
         end
         OP_LOAD: begin
            gen_state_in = draw_x;
            z_in         = draw_x ^ (draw_x >> SHIFT_FIRST);
         end
         OP_MUL_LL: begin
            prod_in = mul_out;
         end
         OP_MUL_HL: begin
            mul_opa = z_ff[DATA_W-1:HALF_W];
            acc_in  = prod_ff;
            prod_in = mul_out;
         end
         OP_MUL_LH: begin
            mul_opb = mul_const[DATA_W-1:HALF_W];
            acc_in  = fold_sum;
            prod_in = mul_out;
         end
         OP_FOLD27: begin
            z_in = fold_sum ^ (fold_sum >> SHIFT_SECOND);
         end
         OP_FOLD31: begin
            z_in   = fold_sum ^ (fold_sum >> SHIFT_THIRD);
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            z_in = {z_ff[DATA_W-2:0], 1'b0};
            if (div_shift >= {1'b0, bound_ff}) begin
               rem_in = div_diff[DATA_W-1:0];
            end else begin
               rem_in = div_shift[DATA_W-1:0];
            end
         end
         OP_PUT_GEN: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = masked_word;
            rsp_bytes_in = chunk;
            rsp_last_in  = status.last_chunk;
            remain_in    = remain_ff - CNT_W'(chunk);
         end
         OP_PUT_UNI: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rem_ff;
            rsp_bytes_in = VALID_BYTES_W'(WORD_BYTES);
            rsp_last_in  = 1'b1;
         end
         OP_PUT_ZERO: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_bytes_in = VALID_BYTES_W'(WORD_BYTES);
            rsp_last_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_valid_bytes = rsp_bytes_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* design/splitmix64_random_source.sv */
// A splitmix64 random source with one 64-bit state word that resets to zero,
// meaning unseeded; while the state is zero every draw starts from the
// request's entropy word instead. A seed request loads the state from entropy
// and is taken with no result beat. A generate request gives
// ceil(byte_count/8) beats, byte_count saturating at MAX_REQUEST_BYTES, each
// beat carrying a fresh draw with its unused high bytes zeroed, its count of
// valid low bytes and a last flag on the final beat; a byte_count of zero
// gives no beat. A uniform request gives one beat holding the draw modulo
// bound, or zero without a draw when bound is zero. Command code three is
// taken and dropped. One request is worked at a time: each draw runs on a
// single shared 32x32 multiplier (three partial products for each of the two
// 64-bit mixing multiplies), and the remainder unit of a uniform request
// retires one dividend bit per cycle. The result beat sits in an output
// register, so the next draw or the next request proceeds while a beat
// waits for the sink.
module splitmix64_random_source import sm64_pkg::*; #(
   parameter int MAX_REQUEST_BYTES = DEFAULT_MAX_REQUEST_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   sm64_req_if.sink   req,
   sm64_rsp_if.source rsp
);

   // Command and status between the sequencer and the datapath.
   sm64_dp_cmd_type    dp_cmd;
   sm64_dp_status_type dp_status;

   // The sequencer owns the request handshake and steps the datapath through
   // the draw, the mixing multiplies and the remainder iterations.
   sm64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .status    (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // The datapath holds the generator state, the captured request, the
   // shared multiplier, the remainder unit and the output register.
   sm64_datapath #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .status          (dp_status),
      .req_byte_count  (req.byte_count),
      .req_bound       (req.bound),
      .req_entropy     (req.entropy),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_value       (rsp.value),
      .rsp_valid_bytes (rsp.valid_bytes),
      .rsp_last        (rsp.last)
   );

endmodule

/* design/sm64_port_checker.sv */
module sm64_port_checker import sm64_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [CMD_W-1:0]          req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [VALID_BYTES_W-1:0]  rsp_valid_bytes,
   input logic                      rsp_last
);

   // A result beat stays offered until the sink takes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   // A uniform request always keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_UNIFORM) |=> !req_ready)
      else $error("new request taken right after a uniform request");

   // A short word can only be the final beat of a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_valid_bytes != VALID_BYTES_W'(WORD_BYTES)) |-> rsp_last)
      else $error("partial word without last flag");

endmodule

bind splitmix64_random_source sm64_port_checker u_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_cmd         (req.cmd),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_valid_bytes (rsp.valid_bytes),
   .rsp_last        (rsp.last)
);
